// File: sv/rle_sprite_row_decoder_defines.svh
// Assertion macros for the sprite row decoder checker.
`ifndef RLE_SPRITE_ROW_DECODER_DEFINES_SVH
`define RLE_SPRITE_ROW_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int COORD_WIDTH     = 12;
	localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int COL_W           = (COORD_WIDTH > 12) ? COORD_WIDTH : 12;

	localparam logic [COORD_WIDTH-1:0] CMAX = '1;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PAL   = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DLEN   = 2'd2;

	typedef struct packed {
		logic [11:0] width;
		logic [11:0] height;
		logic [23:0] dlen;
	} cfg_t;

	typedef struct packed {
		logic        res;
		logic        pix;
		logic [11:0] x;
		logic [11:0] y;
		logic        done;
	} dec_res_t;

endpackage

`default_nettype wire

// File: sv/rsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/rsd_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_palette (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        we,
	input  wire logic [7:0]  waddr,
	input  wire logic [23:0] wdata,
	input  wire logic        re,
	input  wire logic [7:0]  raddr,
	output logic      [23:0] color
);

	localparam int AW = rsd_pkg::PAL_AW;

	logic [rsd_pkg::PALETTE_ENTRIES-1:0] vld_q;
	logic                                ok_q;
	logic                                w_in_range;
	logic                                r_in_range;
	logic [23:0]                         ram_rdata;

	assign w_in_range = {1'b0, waddr} < 9'(rsd_pkg::PALETTE_ENTRIES);
	assign r_in_range = {1'b0, raddr} < 9'(rsd_pkg::PALETTE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ok_q  <= 1'b0;
		end else begin
			if (we && w_in_range) begin
				vld_q[waddr[AW-1:0]] <= 1'b1;
			end
			if (re) begin
				ok_q <= r_in_range && vld_q[raddr[AW-1:0]];
			end
		end
	end

	rsd_ram #(
		.WIDTH(24),
		.DEPTH(rsd_pkg::PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we && w_in_range),
		.waddr(waddr[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr[AW-1:0]),
		.rdata(ram_rdata)
	);

	// unwritten entries read as zero
	assign color = ok_q ? ram_rdata : 24'd0;

endmodule

`default_nettype wire

// File: sv/rsd_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_decoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        data_byte,
	input  wire rsd_pkg::cfg_t     cfg,
	output rsd_pkg::dec_res_t      res
);

	localparam int CW    = rsd_pkg::COORD_WIDTH;
	localparam int COL_W = rsd_pkg::COL_W;
	localparam int SUM_W = COL_W + 1;

	localparam logic [2:0] PH_LEN   = 3'd0;
	localparam logic [2:0] PH_SKIP  = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_PIXEL = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	logic [2:0]       phase_q, phase_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [CW-1:0]    row_q, row_d;
	logic [7:0]       len_q, len_d;
	logic [8:0]       used_q, used_d;
	logic [7:0]       opq_q, opq_d;
	logic [23:0]      cons_q, cons_d;

	logic [23:0]      cons_inc;
	logic [8:0]       used_inc;
	logic             early_now;
	logic             early_bump;
	logic [CW-1:0]    row_inc;
	logic [CW-1:0]    row_inc2;
	logic             row_end;
	logic             row_inc_end;
	logic             row_inc2_end;
	logic [SUM_W-1:0] sum_x;
	logic             skip_end;
	logic [COL_W-1:0] col_inc;
	logic             col_at_w;
	logic             col_inc_at_w;
	logic             used_reach;
	logic [7:0]       opq_dec;
	logic             fin;
	logic             do_after;
	logic             pix;

	assign cons_inc     = (cons_q != '1) ? cons_q + 24'd1 : cons_q;
	assign used_inc     = (used_q != '1) ? used_q + 9'd1 : used_q;
	assign early_now    = ({1'b0, cons_q} + 25'd1) >= {1'b0, cfg.dlen};
	assign early_bump   = ({1'b0, cons_inc} + 25'd1) >= {1'b0, cfg.dlen};
	assign row_inc      = (row_q < rsd_pkg::CMAX) ? row_q + CW'(1) : row_q;
	assign row_inc2     = (row_inc < rsd_pkg::CMAX) ? row_inc + CW'(1) : row_inc;
	assign row_end      = COL_W'(row_q) >= COL_W'(cfg.height);
	assign row_inc_end  = COL_W'(row_inc) >= COL_W'(cfg.height);
	assign row_inc2_end = COL_W'(row_inc2) >= COL_W'(cfg.height);
	assign sum_x        = {1'b0, col_q} + SUM_W'(data_byte);
	assign skip_end     = sum_x >= SUM_W'(cfg.width);
	assign col_inc      = (col_q < COL_W'(rsd_pkg::CMAX)) ? col_q + COL_W'(1) : col_q;
	assign col_at_w     = col_q >= COL_W'(cfg.width);
	assign col_inc_at_w = col_inc >= COL_W'(cfg.width);
	assign used_reach   = used_inc >= {1'b0, len_q};
	assign opq_dec      = (opq_q != 8'd0) ? opq_q - 8'd1 : 8'd0;

	always_comb begin
		phase_d  = phase_q;
		col_d    = col_q;
		row_d    = row_q;
		len_d    = len_q;
		used_d   = used_q;
		opq_d    = opq_q;
		cons_d   = cons_q;
		fin      = 1'b0;
		do_after = 1'b0;
		pix      = 1'b0;
		res      = '0;
		if (accept) begin
			unique case (kind)
				rsd_pkg::KIND_START: begin
					phase_d = PH_LEN;
					col_d   = '0;
					row_d   = '0;
					len_d   = '0;
					used_d  = '0;
					opq_d   = '0;
					cons_d  = '0;
				end
				rsd_pkg::KIND_DATA: begin
					unique case (phase_q)
						PH_LEN: begin
							if (row_end) begin
								fin = 1'b1;
							end else begin
								used_d = 9'd1;
								cons_d = cons_inc;
								len_d  = data_byte;
								col_d  = '0;
								if (data_byte == 8'd0) begin
									row_d = row_inc;
									if (row_inc_end) fin = 1'b1;
									else phase_d = PH_LEN;
								end else begin
									phase_d = PH_SKIP;
								end
							end
						end
						PH_SKIP: begin
							if (skip_end) begin
								if (early_now) begin
									fin = 1'b1;
								end else begin
									row_d = row_inc;
									if (row_inc_end) begin
										fin = 1'b1;
									end else begin
										// reuse the skip byte as the next row's length
										used_d = 9'd1;
										cons_d = cons_inc;
										len_d  = data_byte;
										col_d  = '0;
										if (data_byte == 8'd0) begin
											row_d = row_inc2;
											if (row_inc2_end) fin = 1'b1;
											else phase_d = PH_LEN;
										end else begin
											phase_d = PH_SKIP;
										end
									end
								end
							end else begin
								col_d   = sum_x[COL_W-1:0];
								used_d  = used_inc;
								cons_d  = cons_inc;
								phase_d = PH_COUNT;
							end
						end
						PH_COUNT: begin
							used_d = used_inc;
							cons_d = cons_inc;
							opq_d  = data_byte;
							if (data_byte != 8'd0) phase_d = PH_PIXEL;
							else do_after = 1'b1;
						end
						PH_PIXEL: begin
							pix    = !col_at_w;
							used_d = used_inc;
							cons_d = cons_inc;
							col_d  = col_inc;
							opq_d  = opq_dec;
							if (opq_dec == 8'd0) do_after = 1'b1;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
			if (do_after) begin
				if (((phase_q == PH_PIXEL) ? col_inc_at_w : col_at_w) || used_reach) begin
					if (early_bump) begin
						fin = 1'b1;
					end else begin
						row_d = row_inc;
						if (row_inc_end) fin = 1'b1;
						else phase_d = PH_LEN;
					end
				end else begin
					phase_d = PH_SKIP;
				end
			end
			if (fin) begin
				phase_d = PH_DONE;
			end
			res.res  = pix || fin;
			res.pix  = pix;
			res.x    = pix ? 12'(col_q) : 12'd0;
			res.y    = pix ? 12'(row_q) : 12'd0;
			res.done = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			col_q   <= '0;
			row_q   <= '0;
			len_q   <= '0;
			used_q  <= '0;
			opq_q   <= '0;
			cons_q  <= '0;
		end else begin
			phase_q <= phase_d;
			col_q   <= col_d;
			row_q   <= row_d;
			len_q   <= len_d;
			used_q  <= used_d;
			opq_q   <= opq_d;
			cons_q  <= cons_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/rle_sprite_row_decoder.sv
// A result is registered in the palette read stage and then in the output register after its input beat is accepted.
// Throughput: one input beat per cycle unless stalled; each beat needs one palette RAM read at most.
// The input stalls only when both the palette read stage and the output register are full and out_stall is high.
// Reset (arst_n low) clears the decode state, the palette valid bits and the pipeline;
// image_width returns to 1, image_height and data_length to 0, and the palette reads zero.
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_row_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  palette_index,
	input  wire logic [23:0] palette_color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             pixel_valid,
	output logic      [11:0] pixel_x,
	output logic      [11:0] pixel_y,
	output logic      [23:0] pixel_color,
	output logic             image_done,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	rsd_pkg::cfg_t     cfg_q;
	rsd_pkg::dec_res_t dec;
	logic              accept;
	logic              s2_load;
	logic [23:0]       pal_color;

	logic              vld_s1;
	logic              pix_s1;
	logic [11:0]       x_s1;
	logic [11:0]       y_s1;
	logic              done_s1;

	logic              vld_s2;
	logic              pix_s2;
	logic [11:0]       x_s2;
	logic [11:0]       y_s2;
	logic [23:0]       color_s2;
	logic              done_s2;

	assign cfg_ready = 1'b1;
	assign s2_load   = !vld_s2 || !out_stall;
	assign in_stall  = vld_s1 && !s2_load;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 12'd1;
			cfg_q.height <= 12'd0;
			cfg_q.dlen   <= 24'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rsd_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data[11:0];
				rsd_pkg::REG_HEIGHT: cfg_q.height <= cfg_data[11:0];
				rsd_pkg::REG_DLEN:   cfg_q.dlen   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rsd_decoder u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (kind),
		.data_byte(data_byte),
		.cfg      (cfg_q),
		.res      (dec)
	);

	rsd_palette u_pal (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (accept && (kind == rsd_pkg::KIND_PAL)),
		.waddr (palette_index),
		.wdata (palette_color),
		.re    (dec.pix),
		.raddr (data_byte),
		.color (pal_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (dec.res) vld_s1 <= 1'b1;
			else if (s2_load) vld_s1 <= 1'b0;
			if (s2_load) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dec.res) begin
			pix_s1  <= dec.pix;
			x_s1    <= dec.x;
			y_s1    <= dec.y;
			done_s1 <= dec.done;
		end
		if (s2_load && vld_s1) begin
			pix_s2   <= pix_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			color_s2 <= pix_s1 ? pal_color : 24'd0;
			done_s2  <= done_s1;
		end
	end

	assign out_valid   = vld_s2;
	assign pixel_valid = pix_s2;
	assign pixel_x     = x_s2;
	assign pixel_y     = y_s2;
	assign pixel_color = color_s2;
	assign image_done  = done_s2;

endmodule

`default_nettype wire

// File: sv/rsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rle_sprite_row_decoder_defines.svh"

module rsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        pixel_valid,
	input wire logic [11:0] pixel_x,
	input wire logic [11:0] pixel_y,
	input wire logic [23:0] pixel_color,
	input wire logic        image_done
);

	logic        fields_zero;
	logic [49:0] beat;

	assign fields_zero = ((pixel_x | pixel_y) == 12'd0) && (pixel_color == 24'd0);
	assign beat        = {pixel_valid, pixel_x, pixel_y, pixel_color, image_done};

	`RSD_ASSERT_NOW(a_no_empty_beat, clk, arst_n, out_valid, pixel_valid || image_done, "empty beat")
	`RSD_ASSERT_NOW(a_blank_fields, clk, arst_n, out_valid && !pixel_valid, fields_zero, "not blank")
	`RSD_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "stall, free out")
	`RSD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(beat), "moved")

endmodule

bind rle_sprite_row_decoder rsd_checker u_rsd_checker (.*);

`default_nettype wire

// File: test/sprite_pixel_checker.sv
`timescale 1ns / 1ps

module sprite_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_color,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        pixel_valid,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic [23:0] pixel_color,
	input  logic        image_done,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef enum logic [2:0] {
		AWAIT_LEN,
		AWAIT_SKIP,
		AWAIT_COUNT,
		AWAIT_INDEX,
		IMAGE_OVER
	} phase_e;

	typedef struct packed {
		logic        pix;
		logic [11:0] x;
		logic [11:0] y;
		logic [23:0] color;
		logic        done;
	} pixel_t;

	logic [11:0] img_w;
	logic [11:0] img_h;
	logic [23:0] img_len;
	logic [23:0] palette_mem [rsd_pkg::PALETTE_ENTRIES];

	phase_e      phase;
	logic [11:0] column;
	logic [11:0] row;
	logic [7:0]  row_len;
	logic [8:0]  row_used;
	logic [7:0]  opaque_left;
	logic [23:0] consumed;
	logic        finished;

	pixel_t expected_pixels [$];

	function automatic void clear_decode();
		phase = AWAIT_LEN;
		column = '0;
		row = '0;
		row_len = '0;
		row_used = '0;
		opaque_left = '0;
		consumed = '0;
	endfunction

	function automatic void end_image();
		phase = IMAGE_OVER;
		finished = 1'b1;
	endfunction

	function automatic void count_byte();
		if (consumed != 24'hFFFFFF)
			consumed++;
		if (row_used != 9'd511)
			row_used++;
	endfunction

	function automatic bit past_data_end();
		return {1'b0, consumed} + 25'd1 >= {1'b0, img_len};
	endfunction

	function automatic void advance_row(input bit check_len);
		if (check_len && past_data_end()) begin
			end_image();
			return;
		end
		if (row != rsd_pkg::CMAX)
			row++;
		if (row >= img_h)
			end_image();
		else
			phase = AWAIT_LEN;
	endfunction

	function automatic void start_row(input logic [7:0] b);
		if (row >= img_h) begin
			end_image();
			return;
		end
		row_used = '0;
		count_byte();
		row_len = b;
		column = '0;
		if (b == 8'd0)
			advance_row(1'b0);
		else
			phase = AWAIT_SKIP;
	endfunction

	function automatic void close_run();
		if (column >= img_w || row_used >= {1'b0, row_len})
			advance_row(1'b1);
		else
			phase = AWAIT_SKIP;
	endfunction

	function automatic void predict_beat(input logic [1:0] k, input logic [7:0] b,
			input logic [7:0] idx, input logic [23:0] color);
		pixel_t      res;
		logic [12:0] reach;
		res = '0;
		finished = 1'b0;
		case (k)
		rsd_pkg::KIND_PAL: palette_mem[idx] = color;
		rsd_pkg::KIND_START: clear_decode();
		rsd_pkg::KIND_DATA: begin
			case (phase)
			AWAIT_LEN: start_row(b);
			AWAIT_SKIP: begin
				reach = {1'b0, column} + {5'd0, b};
				if (reach >= {1'b0, img_w}) begin
					if (past_data_end()) begin
						end_image();
					end else begin
						if (row != rsd_pkg::CMAX)
							row++;
						if (row >= img_h)
							end_image();
						else
							start_row(b);
					end
				end else begin
					column = reach[11:0];
					count_byte();
					phase = AWAIT_COUNT;
				end
			end
			AWAIT_COUNT: begin
				count_byte();
				opaque_left = b;
				if (b != 8'd0)
					phase = AWAIT_INDEX;
				else
					close_run();
			end
			AWAIT_INDEX: begin
				if (column < img_w) begin
					res.pix = 1'b1;
					res.x = column;
					res.y = row;
					res.color = palette_mem[b];
				end
				count_byte();
				if (column != rsd_pkg::CMAX)
					column++;
				if (opaque_left != 8'd0)
					opaque_left--;
				if (opaque_left == 8'd0)
					close_run();
			end
			default: ;
			endcase
		end
		default: ;
		endcase
		res.done = finished;
		if (res.pix || res.done)
			expected_pixels.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 100)
			$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_t want;
		if (!arst_n) begin
			img_w = 12'd1;
			img_h = '0;
			img_len = '0;
			for (int i = 0; i < rsd_pkg::PALETTE_ENTRIES; i++)
				palette_mem[i] = '0;
			clear_decode();
			expected_pixels.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				rsd_pkg::REG_WIDTH: img_w = cfg_data[11:0];
				rsd_pkg::REG_HEIGHT: img_h = cfg_data[11:0];
				rsd_pkg::REG_DLEN: img_len = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result beat with nothing outstanding", 32'(pixel_x),
						32'd0);
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_valid !== want.pix)
						report_mismatch("pixel_valid", 32'(pixel_valid), 32'(want.pix));
					if (pixel_x !== want.x)
						report_mismatch("pixel_x", 32'(pixel_x), 32'(want.x));
					if (pixel_y !== want.y)
						report_mismatch("pixel_y", 32'(pixel_y), 32'(want.y));
					if (pixel_color !== want.color)
						report_mismatch("pixel_color", 32'(pixel_color), 32'(want.color));
					if (image_done !== want.done)
						report_mismatch("image_done", 32'(image_done), 32'(want.done));
				end
			end
			if (in_valid && !in_stall)
				predict_beat(kind, data_byte, palette_index, palette_color);
			pending = expected_pixels.size();
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [7:0]  index;
		logic [23:0] color;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = rsd_pkg::KIND_DATA;
	logic [7:0]  data_byte = '0;
	logic [7:0]  palette_index = '0;
	logic [23:0] palette_color = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        pixel_valid;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [23:0] pixel_color;
	logic        image_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = rsd_pkg::REG_WIDTH;
	logic [23:0] cfg_data = '0;

	int    errors;
	int    pending;
	bit    hold_req = 1'b0;
	int    burst_left = 0;
	beat_t beat_q [$];

	rle_sprite_row_decoder dut (.*);

	sprite_pixel_checker pixel_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void push_beat(input logic [1:0] k, input logic [7:0] b,
			input logic [7:0] idx, input logic [23:0] color);
		beat_q.push_back('{kind: k, data: b, index: idx, color: color});
	endfunction

	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 15));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 68)
			return $urandom_range(3, 20);
		if (r < 88)
			return $urandom_range(21, 60);
		return $urandom_range(61, 255);
	endfunction

	// data byte, now and then preceded by a palette load, a junk beat or a restart
	function automatic void push_data(input logic [7:0] b);
		int r;
		r = $urandom_range(0, 199);
		if (r < 6)
			push_beat(rsd_pkg::KIND_PAL, 8'($urandom), pick_index(), 24'($urandom));
		else if (r < 8)
			push_beat(KIND_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
		else if (r < 10)
			push_beat(rsd_pkg::KIND_DATA, 8'($urandom), 8'($urandom), 24'($urandom));
		else if (r == 10)
			push_beat(rsd_pkg::KIND_START, 8'($urandom), 8'($urandom), 24'($urandom));
		push_beat(rsd_pkg::KIND_DATA, b, 8'($urandom), 24'($urandom));
	endfunction

	function automatic void gen_image(input int w, input int h);
		int rows, carry, len, col, used, room, s, c;
		push_beat(rsd_pkg::KIND_START, 8'($urandom), 8'($urandom), 24'($urandom));
		repeat ($urandom_range(0, 5))
			push_beat(rsd_pkg::KIND_PAL, 8'($urandom), pick_index(), 24'($urandom));
		rows = (h > 6) ? $urandom_range(1, 6) : h;
		carry = -1;
		for (int r = 0; r < rows; r++) begin
			if (carry >= 0) begin
				len = carry;
			end else begin
				len = pick_len();
				push_data(8'(len));
			end
			carry = -1;
			if (len == 0)
				continue;
			col = 0;
			used = 1;
			forever begin
				room = w - col;
				// skip past the width: this byte opens the next row
				if (room <= 255 && $urandom_range(0, 9) == 0) begin
					carry = $urandom_range(room, 255);
					push_data(8'(carry));
					break;
				end
				if ($urandom_range(0, 9) == 0)
					s = $urandom_range(0, (room > 256) ? 255 : room - 1);
				else
					s = $urandom_range(0, (room > 13) ? 12 : room - 1);
				push_data(8'(s));
				col += s;
				c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
				push_data(8'(c));
				repeat (c)
					push_data(pick_index());
				col += c;
				used += 2 + c;
				if (used >= len || col >= w)
					break;
			end
		end
		repeat ($urandom_range(0, 2))
			push_data(8'($urandom));
	endfunction

	task automatic send_beats();
		beat_t b;
		int    gap;
		while (beat_q.size() != 0) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				if ($urandom_range(0, 9) == 0)
					burst_left = $urandom_range(100, 300);
				else
					burst_left = $urandom_range(1, 24);
			end
			b = beat_q.pop_front();
			in_valid <= 1'b1;
			kind <= b.kind;
			data_byte <= b.data;
			palette_index <= b.index;
			palette_color <= b.color;
			do @(posedge clk); while (in_stall);
			burst_left--;
		end
		in_valid <= 1'b0;
	endtask

	task automatic write_regs(input logic [11:0] w, input logic [11:0] h,
			input logic [23:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= rsd_pkg::REG_WIDTH;
		cfg_data <= {12'd0, w};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= rsd_pkg::REG_HEIGHT;
		cfg_data <= {12'd0, h};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= rsd_pkg::REG_DLEN;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// wait for every outstanding result beat, then let beats without results clear the pipe
	task automatic settle();
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int mode, span, tick;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 150);
			repeat (span) begin
				@(posedge clk);
				tick++;
				if (hold_req) begin
					hold_req = 1'b0;
					out_stall <= 1'b1;
					repeat (300) @(posedge clk);
				end else begin
					case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= (tick % 5 < 2);
					default: out_stall <= ($urandom_range(0, 9) < 7);
					endcase
				end
			end
		end
	end

	initial begin
		int w, h, d;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_beat(rsd_pkg::KIND_DATA, 8'hA5, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'h5A, 8'hFF, 24'hFFFFFF);
		push_beat(KIND_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF);
		send_beats();
		settle();

		write_regs(12'd4, 12'd3, 24'hFFFFFF);
		push_beat(rsd_pkg::KIND_START, 8'h00, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd6, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd1, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd2, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd0, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd255, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd5, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd3, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd3, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd7, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd9, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd11, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd0, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'h42, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_PAL, 8'h00, 8'hFF, 24'hFFFFFF);
		push_beat(rsd_pkg::KIND_PAL, 8'h00, 8'h00, 24'hABCDEF);
		send_beats();
		settle();

		write_regs(12'd4095, 12'd4095, 24'd0);
		push_beat(rsd_pkg::KIND_START, 8'h00, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd3, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd0, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd1, 8'h00, 24'h000000);
		push_beat(rsd_pkg::KIND_DATA, 8'd255, 8'h00, 24'h000000);
		send_beats();
		settle();

		for (int p = 0; p < 12; p++) begin
			if ($urandom_range(0, 1) == 0)
				w = $urandom_range(1, 8);
			else if ($urandom_range(0, 4) != 0)
				w = $urandom_range(9, 64);
			else
				w = $urandom_range(65, 4095);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 4095) : $urandom_range(1, 5);
			case ($urandom_range(0, 3))
			0: d = $urandom_range(0, 80);
			1: d = $urandom_range(0, 24'hFFFFFF);
			default: d = 24'hFFFFFF;
			endcase
			case (p)
			0: w = 1;
			1: w = 4095;
			2: h = 0;
			3: h = 4095;
			4: d = 0;
			5: d = 24'hFFFFFF;
			7: begin
				w = 16;
				h = 6;
				d = 24'hFFFFFF;
			end
			default: ;
			endcase
			write_regs(12'(w), 12'(h), 24'(d));
			while (beat_q.size() < 110)
				gen_image(w, h);
			if (p == 7)
				hold_req = 1'b1;
			send_beats();
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/rsd_pkg.sv
sv/rsd_ram.sv
sv/rsd_palette.sv
sv/rsd_decoder.sv
sv/rle_sprite_row_decoder.sv
sv/rsd_checker.sv
test/sprite_pixel_checker.sv
test/testbench.sv
